@@ rtl/orf_pkg.sv @@
// shared types, constants and the mask table for the reply framer
// no dependencies; compiled first
package orf_pkg;

   localparam int BURST_MAX = 8;
   localparam int IDX_W     = $clog2(BURST_MAX);

   localparam logic OP_START = 1'b0;
   localparam logic OP_DATA  = 1'b1;

   localparam logic CSR_OBF_EN  = 1'b0;
   localparam logic CSR_MAX_PAY = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_OVERSIZE = 2'd1;
   localparam logic [1:0] ST_STRAY    = 2'd2;

   localparam logic [7:0] HDR_B0  = 8'hAB;
   localparam logic [7:0] HDR_B1  = 8'hCD;
   localparam logic [7:0] FTR_B0  = 8'hDC;
   localparam logic [7:0] FTR_B1  = 8'hBA;
   localparam logic [7:0] PAD_FF  = 8'hFF;

   localparam logic        OBF_EN_RST  = 1'b1;
   localparam logic [15:0] MAX_PAY_RST = 16'd144;

   typedef struct packed {
      logic [BURST_MAX-1:0][7:0] bytes;
      logic [IDX_W-1:0]          last_idx;
      logic                      done;
      logic [1:0]                status;
   } burst_type;

   function automatic logic [7:0] mask_byte(input logic [3:0] pos);
      logic [7:0] m;
      case (pos)
         4'd0:    m = 8'h16;
         4'd1:    m = 8'h6C;
         4'd2:    m = 8'h14;
         4'd3:    m = 8'hE6;
         4'd4:    m = 8'h2E;
         4'd5:    m = 8'h91;
         4'd6:    m = 8'h0D;
         4'd7:    m = 8'h40;
         4'd8:    m = 8'h21;
         4'd9:    m = 8'h35;
         4'd10:   m = 8'hD5;
         4'd11:   m = 8'h40;
         4'd12:   m = 8'h13;
         4'd13:   m = 8'h03;
         4'd14:   m = 8'hE9;
         default: m = 8'h80;
      endcase
      return m;
   endfunction

endpackage

@@ rtl/orf_req_if.sv @@
// request channel of the reply framer: valid/ready plus start or payload fields
// depends on nothing
interface orf_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [15:0] payload_size;
   logic [7:0]  data_byte;

   modport source (output valid, op, payload_size, data_byte, input ready);
   modport sink   (input valid, op, payload_size, data_byte, output ready);
endinterface

@@ rtl/orf_rsp_if.sv @@
// response channel of the reply framer: one wire byte per beat
// depends on nothing
interface orf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       frame_done;
   logic [1:0] status;

   modport source (output valid, out_byte, run_last, frame_done, status, input ready);
   modport sink   (input valid, out_byte, run_last, frame_done, status, output ready);
endinterface

@@ rtl/orf_frame_ctl.sv @@
// frame state, config registers and burst build for one request beat
// depends on orf_pkg and orf_req_if
module orf_frame_ctl (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [15:0]       csr_wdata,
   orf_req_if.sink           req,
   input  logic              out_free,
   output logic              load,
   output orf_pkg::burst_type burst
);
   import orf_pkg::*;

   logic        obf_en_ff, obf_en_in;
   logic [15:0] max_pay_ff, max_pay_in;
   logic        open_ff, open_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] sent_ff, sent_in;

   logic        fire;
   logic        end_hit;
   logic [15:0] sent_inc;
   logic [3:0]  pad_pos;
   logic [7:0]  pad0, pad1;

   always_comb begin
      obf_en_in  = obf_en_ff;
      max_pay_in = max_pay_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_OBF_EN:  obf_en_in  = csr_wdata[0];
            CSR_MAX_PAY: max_pay_in = csr_wdata;
            default:     ;
         endcase
      end
   end

   always_comb begin
      fire      = req.valid && out_free;
      req.ready = out_free;
      load      = fire;
      sent_inc  = sent_ff + 16'd1;
      end_hit   = (sent_inc == len_ff);
      pad_pos   = (req.op == OP_START) ? req.payload_size[3:0] : len_ff[3:0];
      pad0      = obf_en_ff ? (mask_byte(pad_pos) ^ PAD_FF) : PAD_FF;
      pad1      = obf_en_ff ? (mask_byte(pad_pos + 4'd1) ^ PAD_FF) : PAD_FF;

      burst   = '0;
      open_in = open_ff;
      len_in  = len_ff;
      sent_in = sent_ff;

      case (req.op)
         OP_START: begin
            if (req.payload_size > max_pay_ff) begin
               burst.status = ST_OVERSIZE;
               open_in      = 1'b0;
               len_in       = '0;
               sent_in      = '0;
            end else begin
               burst.bytes[0] = HDR_B0;
               burst.bytes[1] = HDR_B1;
               burst.bytes[2] = req.payload_size[7:0];
               burst.bytes[3] = req.payload_size[15:8];
               len_in  = req.payload_size;
               sent_in = '0;
               if (req.payload_size == 16'd0) begin
                  burst.bytes[4] = pad0;
                  burst.bytes[5] = pad1;
                  burst.bytes[6] = FTR_B0;
                  burst.bytes[7] = FTR_B1;
                  burst.last_idx = IDX_W'(7);
                  burst.done     = 1'b1;
                  open_in        = 1'b0;
               end else begin
                  burst.last_idx = IDX_W'(3);
                  open_in        = 1'b1;
               end
            end
         end
         default: begin
            if (!open_ff) begin
               burst.status = ST_STRAY;
            end else begin
               burst.bytes[0] = req.data_byte ^ (obf_en_ff ? mask_byte(sent_ff[3:0]) : 8'h00);
               sent_in = sent_inc;
               if (end_hit) begin
                  burst.bytes[1] = pad0;
                  burst.bytes[2] = pad1;
                  burst.bytes[3] = FTR_B0;
                  burst.bytes[4] = FTR_B1;
                  burst.last_idx = IDX_W'(4);
                  burst.done     = 1'b1;
                  open_in        = 1'b0;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         obf_en_ff  <= OBF_EN_RST;
         max_pay_ff <= MAX_PAY_RST;
         open_ff    <= 1'b0;
         len_ff     <= '0;
         sent_ff    <= '0;
      end else begin
         obf_en_ff  <= obf_en_in;
         max_pay_ff <= max_pay_in;
         if (fire) begin
            open_ff <= open_in;
            len_ff  <= len_in;
            sent_ff <= sent_in;
         end
      end
   end

endmodule

@@ rtl/orf_burst_out.sv @@
// result register and byte sequencer: plays out one built burst a beat per cycle while the response port is ready
// depends on orf_pkg and orf_rsp_if
module orf_burst_out (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  orf_pkg::burst_type burst,
   output logic               out_free,
   orf_rsp_if.source          rsp
);
   import orf_pkg::*;

   logic             valid_ff, valid_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   burst_type        burst_ff;
   logic             at_last;

   always_comb begin
      at_last  = (idx_ff == burst_ff.last_idx);
      out_free = !valid_ff || (rsp.ready && at_last);

      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (valid_ff && rsp.ready) begin
         if (at_last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end

      rsp.valid      = valid_ff;
      rsp.out_byte   = burst_ff.bytes[idx_ff];
      rsp.run_last   = at_last;
      rsp.frame_done = burst_ff.done && at_last;
      rsp.status     = burst_ff.status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         burst_ff <= burst;
      end
   end

endmodule

@@ rtl/obfuscated_reply_framer.sv @@
// reply framer top: frame control feeding a registered byte sequencer
// first response beat is registered: it comes in the cycle after the request beat is taken
// throughput: one request per cycle for single-byte results while the response port is ready; a request making
//   n bytes holds the input until its last byte is taken, set by the one-byte-per-cycle response port
// reset: synchronous active high, clears frame state and restores config defaults
module obfuscated_reply_framer (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   orf_req_if.sink     req_ch,
   orf_rsp_if.source   rsp_ch
);
   import orf_pkg::*;

   logic      out_free;
   logic      load;
   burst_type burst;

   orf_frame_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_ch),
      .out_free  (out_free),
      .load      (load),
      .burst     (burst)
   );

   orf_burst_out u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .burst    (burst),
      .out_free (out_free),
      .rsp      (rsp_ch)
   );

endmodule

@@ rtl/orf_checker.sv @@
// port-level checks for the reply framer, bound to the top level
// depends on orf_pkg and obfuscated_reply_framer
module orf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last,
   input logic       rsp_frame_done,
   input logic [1:0] rsp_status
);
   import orf_pkg::*;

   // held beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_done_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_out_byte == FTR_B1 && rsp_run_last
         && rsp_status == ST_OK)
      else $error("frame end beat malformed");

   a_err_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_out_byte == 8'h00 && rsp_run_last
         && !rsp_frame_done)
      else $error("error beat malformed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind obfuscated_reply_framer orf_checker u_orf_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_out_byte   (rsp_ch.out_byte),
   .rsp_run_last   (rsp_ch.run_last),
   .rsp_frame_done (rsp_ch.frame_done),
   .rsp_status     (rsp_ch.status)
);

@@ sim/obfuscated_reply_framer_tb.sv @@
// testbench for obfuscated_reply_framer: directed and random request beats, each
// response beat checked field by field against a frame predictor kept in the bench
// depends on orf_pkg, orf_req_if, orf_rsp_if and the framer rtl
module obfuscated_reply_framer_tb;
   import orf_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MAX_REPORTS    = 10;

   localparam logic [0:15][7:0] OBF_MASK = {
      8'h16, 8'h6C, 8'h14, 8'hE6, 8'h2E, 8'h91, 8'h0D, 8'h40,
      8'h21, 8'h35, 8'hD5, 8'h40, 8'h13, 8'h03, 8'hE9, 8'h80
   };

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_done;
      logic [1:0] status;
   } wire_beat_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_index;
   logic [15:0] csr_wdata;

   orf_req_if req_ch();
   orf_rsp_if rsp_ch();

   // predictor copy of config and frame state
   logic          obf_on;
   logic [15:0]   size_limit;
   logic          frame_open;
   logic [15:0]   frame_len;
   logic [15:0]   bytes_done;
   wire_beat_type expected_wire_q[$];

   int send_idle_pct;
   int recv_idle_pct;
   int hold_left;
   int quiet_cycles = 0;
   int mismatches;
   int items_sent;

   obfuscated_reply_framer i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   always #10 clock = ~clock;

   function automatic void push_beat(input logic [7:0] b, input logic done,
                                     input logic [1:0] st);
      wire_beat_type w;
      w.out_byte   = b;
      w.run_last   = 1'b0;
      w.frame_done = done;
      w.status     = st;
      expected_wire_q.push_back(w);
   endfunction

   function automatic void push_footer(input logic [15:0] size);
      logic [7:0] pad0;
      logic [7:0] pad1;
      logic [3:0] pos;
      pad0 = 8'hFF;
      pad1 = 8'hFF;
      pos  = size[3:0];
      if (obf_on) begin
         pad0 = OBF_MASK[pos] ^ 8'hFF;
         pos  = pos + 4'd1;
         pad1 = OBF_MASK[pos] ^ 8'hFF;
      end
      push_beat(pad0, 1'b0, ST_OK);
      push_beat(pad1, 1'b0, ST_OK);
      push_beat(8'hDC, 1'b0, ST_OK);
      push_beat(8'hBA, 1'b1, ST_OK);
   endfunction

   function automatic void predict_wire_bytes(input logic op, input logic [15:0] size,
                                              input logic [7:0] data);
      logic [7:0] b;
      wire_beat_type w;
      if (op == OP_START) begin
         if (size > size_limit) begin
            frame_open = 1'b0;
            frame_len  = 16'd0;
            bytes_done = 16'd0;
            push_beat(8'h00, 1'b0, ST_OVERSIZE);
         end else begin
            push_beat(8'hAB, 1'b0, ST_OK);
            push_beat(8'hCD, 1'b0, ST_OK);
            push_beat(size[7:0], 1'b0, ST_OK);
            push_beat(size[15:8], 1'b0, ST_OK);
            frame_len  = size;
            bytes_done = 16'd0;
            if (size == 16'd0) begin
               frame_open = 1'b0;
               push_footer(size);
            end else begin
               frame_open = 1'b1;
            end
         end
      end else if (!frame_open) begin
         push_beat(8'h00, 1'b0, ST_STRAY);
      end else begin
         b = data;
         if (obf_on) b = b ^ OBF_MASK[bytes_done[3:0]];
         push_beat(b, 1'b0, ST_OK);
         bytes_done = bytes_done + 16'd1;
         if (bytes_done == frame_len) begin
            frame_open = 1'b0;
            push_footer(frame_len);
         end
      end
      w = expected_wire_q.pop_back();
      w.run_last = 1'b1;
      expected_wire_q.push_back(w);
   endfunction

   function automatic void note_mismatch(input bit has_want, input wire_beat_type want,
                                         input wire_beat_type got);
      if (mismatches < MAX_REPORTS) begin
         if (has_want)
            $display("mismatch: want %h/%b/%b/%0d got %h/%b/%b/%0d",
                     want.out_byte, want.run_last, want.frame_done, want.status,
                     got.out_byte, got.run_last, got.frame_done, got.status);
         else
            $display("unexpected beat: byte %h last %b done %b status %0d",
                     got.out_byte, got.run_last, got.frame_done, got.status);
      end
      mismatches++;
   endfunction

   always @(posedge clock) begin : check_rsp
      wire_beat_type want;
      wire_beat_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            predict_wire_bytes(req_ch.op, req_ch.payload_size, req_ch.data_byte);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.out_byte   = rsp_ch.out_byte;
            got.run_last   = rsp_ch.run_last;
            got.frame_done = rsp_ch.frame_done;
            got.status     = rsp_ch.status;
            if (expected_wire_q.size() == 0) begin
               note_mismatch(1'b0, got, got);
            end else begin
               want = expected_wire_q.pop_front();
               if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
                   got.frame_done !== want.frame_done || got.status !== want.status)
                  note_mismatch(1'b1, want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("obfuscated_reply_framer_tb NOT OK");
         $finish;
      end
   end

   // response side: long hold-off first, else random stalls
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_ch.ready = 1'b0;
         hold_left--;
      end else begin
         rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_item(input logic op, input logic [15:0] size, input logic [7:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.op           = op;
      req_ch.payload_size = size;
      req_ch.data_byte    = data;
      req_ch.valid        = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_start(input logic [15:0] size);
      send_item(OP_START, size, 8'($urandom_range(255)));
   endtask

   task automatic send_data(input logic [7:0] data);
      send_item(OP_DATA, 16'($urandom_range(65535)), data);
   endtask

   task automatic drain_replies();
      req_ch.valid = 1'b0;
      while (expected_wire_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] value);
      drain_replies();
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(posedge clock);
      if (idx == CSR_OBF_EN)
         obf_on = value[0];
      else
         size_limit = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic retune_config();
      logic [15:0] limit;
      write_csr(CSR_OBF_EN, 16'($urandom_range(65535)));
      case ($urandom_range(6))
         0: limit = 16'd0;
         1: limit = 16'd1;
         2: limit = 16'd15;
         3: limit = 16'd144;
         4: limit = 16'($urandom_range(300, 16));
         5: limit = 16'hFFFF;
         default: limit = 16'($urandom_range(65535));
      endcase
      write_csr(CSR_MAX_PAY, limit);
   endtask

   task automatic test_directed_cases();
      send_start(16'd0);
      send_data(8'h5A);
      send_start(16'd3);
      send_data(8'h00);
      send_data(8'hFF);
      send_data(8'h5A);
      send_start(16'd144);
      send_data(8'hFF);
      send_data(8'h00);
      // new start abandons the open frame
      send_start(16'd1);
      send_data(8'hC3);
      send_start(16'd145);
      send_data(8'h11);
      // oversize start closes the open frame
      send_start(16'd2);
      send_data(8'h01);
      send_start(16'hFFFF);
      send_data(8'h22);
      write_csr(CSR_OBF_EN, 16'h0000);
      send_start(16'd1);
      send_data(8'hA5);
      send_start(16'd2);
      send_data(8'h3C);
      // obfuscation turned back on inside a frame
      write_csr(CSR_OBF_EN, 16'h0001);
      send_data(8'h3C);
      write_csr(CSR_MAX_PAY, 16'hFFFF);
      send_start(16'hFFFF);
      send_start(16'd0);
      write_csr(CSR_MAX_PAY, 16'h0000);
      send_start(16'd0);
      send_start(16'd1);
   endtask

   task automatic test_backpressure();
      @(posedge clock);
      hold_left = 300;
      @(negedge clock);
      send_start(16'd20);
      repeat (20) send_data(8'($urandom_range(255)));
      send_start(16'd0);
      send_start(16'd0);
   endtask

   task automatic test_random_traffic(input int n_items);
      int stop_at;
      int next_retune;
      int pick;
      int lim;
      int cap;
      int size;
      int n_data;
      stop_at     = items_sent + n_items;
      next_retune = items_sent;
      while (items_sent < stop_at) begin
         if (items_sent >= next_retune) begin
            retune_config();
            next_retune = items_sent + 40;
         end
         lim  = int'(size_limit);
         pick = $urandom_range(99);
         if (pick < 80) begin
            cap = ($urandom_range(9) == 0) ? 150 : 24;
            if (cap > lim) cap = lim;
            size = $urandom_range(cap);
            n_data = size;
            // truncated frame, left for the next start to abandon
            if (pick >= 70) n_data = (size > 0) ? $urandom_range(size - 1) : 0;
            send_start(16'(size));
            repeat (n_data) send_data(8'($urandom_range(255)));
         end else if (pick < 90) begin
            repeat ($urandom_range(3, 1)) send_data(8'($urandom_range(255)));
         end else if (lim < 65535) begin
            send_start(16'($urandom_range(65535, lim + 1)));
         end else begin
            send_start(16'($urandom_range(65535)));
         end
      end
   endtask

   initial begin
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_index           = CSR_OBF_EN;
      csr_wdata           = 16'd0;
      req_ch.valid        = 1'b0;
      req_ch.op           = OP_START;
      req_ch.payload_size = 16'd0;
      req_ch.data_byte    = 8'd0;
      rsp_ch.ready        = 1'b0;
      hold_left           = 0;
      mismatches          = 0;
      items_sent          = 0;
      send_idle_pct       = 21;
      recv_idle_pct       = 70;
      obf_on              = 1'b1;
      size_limit          = 16'd144;
      frame_open          = 1'b0;
      frame_len           = 16'd0;
      bytes_done          = 16'd0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_random_traffic(130);
      send_idle_pct = 70;
      recv_idle_pct = 21;
      test_random_traffic(130);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_random_traffic(130);

      drain_replies();
      repeat (10) @(negedge clock);
      if (mismatches == 0 && expected_wire_q.size() == 0)
         $display("obfuscated_reply_framer_tb OK");
      else
         $display("obfuscated_reply_framer_tb NOT OK");
      $finish;
   end

endmodule
